[rtl/qefs_pkg.sv]
// Shared types and constants for the quoted/escaped field scanner.
// No dependencies; used by every module under rtl/ except qefs_fifo.
package qefs_pkg;

   localparam int LINE_BITS_DEFAULT   = 32;
   localparam int COLUMN_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int LINE_OUT_BITS  = 32;
   localparam int COL_OUT_BITS   = 16;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELIM_0 = 3'd0,
      CSR_DELIM_1 = 3'd1,
      CSR_DELIM_2 = 3'd2,
      CSR_DELIM_3 = 3'd3,
      CSR_ESCAPE  = 3'd4
   } csr_index_type;

   localparam logic [CSR_DATA_BITS-1:0] DELIM_0_RESET = 64'h0000_1000_0000_0000; // comma
   localparam logic [7:0] ESCAPE_RESET = 8'h5C;

   localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE  = 8'h27;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [1:0] ACT_DROP   = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_TERM   = 2'd2;
   localparam logic [1:0] ACT_EOI    = 2'd3;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_QUOTE  = 2'd1;
   localparam logic [1:0] ERR_ESC_NL = 2'd2;

   // Classified input byte, front to back
   typedef struct packed {
      logic       eoi;
      logic [7:0] data;
      logic       is_delim;
      logic       is_newline;
      logic       is_dquote;
      logic       is_squote;
      logic       is_escape;
   } scan_item_type;

   // One result transaction
   typedef struct packed {
      logic [7:0]               out_byte;
      logic [1:0]               action;
      logic [1:0]               error_code;
      logic [LINE_OUT_BITS-1:0] line_number;
      logic [COL_OUT_BITS-1:0]  column_number;
   } scan_result_type;

endpackage

[rtl/qefs_fifo.sv]
// Small register-based queue used between front and back and on the result side.
// Depends on nothing but its parameters.
module qefs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/qefs_front.sv]
// Front end: configuration registers and byte classification.
// Depends on qefs_pkg.
module qefs_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [qefs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [qefs_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                 cmd,
   input  logic [7:0]                           in_byte,
   output qefs_pkg::scan_item_type              item
);

   logic [qefs_pkg::CSR_DATA_BITS-1:0] delim_ff [4];
   logic [7:0]                         escape_ff;
   logic                               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff[0] <= qefs_pkg::DELIM_0_RESET;
         delim_ff[1] <= '0;
         delim_ff[2] <= '0;
         delim_ff[3] <= '0;
         escape_ff   <= qefs_pkg::ESCAPE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            qefs_pkg::CSR_DELIM_0: delim_ff[0] <= csr_data;
            qefs_pkg::CSR_DELIM_1: delim_ff[1] <= csr_data;
            qefs_pkg::CSR_DELIM_2: delim_ff[2] <= csr_data;
            qefs_pkg::CSR_DELIM_3: delim_ff[3] <= csr_data;
            qefs_pkg::CSR_ESCAPE:  escape_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      item.eoi        = cmd;
      item.data       = in_byte;
      item.is_delim   = delim_ff[in_byte[7:6]][in_byte[5:0]];
      item.is_newline = (in_byte == qefs_pkg::CHAR_NEWLINE);
      item.is_dquote  = (in_byte == qefs_pkg::CHAR_DQUOTE);
      item.is_squote  = (in_byte == qefs_pkg::CHAR_SQUOTE);
      item.is_escape  = (in_byte == escape_ff);
   end

endmodule

[rtl/qefs_back.sv]
// Back end: token state machine and line/column counters.
// Depends on qefs_pkg.
module qefs_back #(
   parameter int LINE_BITS   = qefs_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = qefs_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  qefs_pkg::scan_item_type   item,
   output logic                      in_take,
   input  logic                      out_ready,
   output logic                      out_push,
   output qefs_pkg::scan_result_type result
);

   localparam int LW = (LINE_BITS > qefs_pkg::LINE_OUT_BITS) ?
                       LINE_BITS : qefs_pkg::LINE_OUT_BITS;
   localparam int CW = (COLUMN_BITS > qefs_pkg::COL_OUT_BITS) ?
                       COLUMN_BITS : qefs_pkg::COL_OUT_BITS;
   localparam logic [LW-1:0] LINE_OUT_MAX = LW'({qefs_pkg::LINE_OUT_BITS{1'b1}});
   localparam logic [CW-1:0] COL_OUT_MAX  = CW'({qefs_pkg::COL_OUT_BITS{1'b1}});

   typedef enum logic [2:0] {
      MODE_START,
      MODE_DQ,
      MODE_SQ,
      MODE_SKIP,
      MODE_PLAIN,
      MODE_ESC
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [1:0]             action;
   logic [1:0]             err;
   logic [1:0]             plain_act;
   mode_type               plain_mode;
   logic                   fire;
   logic [LW-1:0]          line_ext;
   logic [CW-1:0]          col_ext;

   assign fire     = in_valid && out_ready;
   assign in_take  = fire;
   assign out_push = fire;

   // unquoted, non-escaped byte
   always_comb begin
      if (item.is_newline || item.is_delim) begin
         plain_act  = qefs_pkg::ACT_TERM;
         plain_mode = MODE_START;
      end else if (item.is_escape) begin
         plain_act  = qefs_pkg::ACT_DROP;
         plain_mode = MODE_ESC;
      end else begin
         plain_act  = qefs_pkg::ACT_APPEND;
         plain_mode = MODE_PLAIN;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      action  = qefs_pkg::ACT_DROP;
      err     = qefs_pkg::ERR_NONE;
      line_in = line_ff;
      col_in  = col_ff;
      if (item.eoi) begin
         if (mode_ff == MODE_DQ || mode_ff == MODE_SQ) begin
            err = qefs_pkg::ERR_QUOTE;
         end
         action  = qefs_pkg::ACT_EOI;
         mode_in = MODE_START;
      end else begin
         unique case (mode_ff)
            MODE_START: begin
               if (item.is_dquote) begin
                  action  = qefs_pkg::ACT_APPEND;
                  mode_in = MODE_DQ;
               end else if (item.is_squote) begin
                  action  = qefs_pkg::ACT_APPEND;
                  mode_in = MODE_SQ;
               end else begin
                  action  = plain_act;
                  mode_in = plain_mode;
               end
            end
            MODE_DQ, MODE_SQ: begin
               if ((mode_ff == MODE_DQ && item.is_dquote) ||
                   (mode_ff == MODE_SQ && item.is_squote)) begin
                  action  = qefs_pkg::ACT_APPEND;
                  mode_in = MODE_SKIP;
               end else if (item.is_newline) begin
                  action  = qefs_pkg::ACT_TERM;
                  err     = qefs_pkg::ERR_QUOTE;
                  mode_in = MODE_START;
               end else begin
                  action  = qefs_pkg::ACT_APPEND;
               end
            end
            MODE_SKIP: begin
               if (item.is_delim) begin
                  action  = qefs_pkg::ACT_TERM;
                  mode_in = MODE_START;
               end
            end
            MODE_ESC: begin
               if (item.is_newline) begin
                  action  = qefs_pkg::ACT_TERM;
                  err     = qefs_pkg::ERR_ESC_NL;
                  mode_in = MODE_START;
               end else begin
                  action  = qefs_pkg::ACT_APPEND;
                  mode_in = MODE_PLAIN;
               end
            end
            default: begin
               action  = plain_act;
               mode_in = plain_mode;
            end
         endcase
         if (item.is_newline) begin
            if (!(&line_ff)) begin
               line_in = line_ff + 1'b1;
            end
            col_in = '0;
         end else if (!(&col_ff)) begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         line_ff <= LINE_BITS'(1);
         col_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

   // counts are reported as they stood before this byte, clipped to the port width
   assign line_ext = LW'(line_ff);
   assign col_ext  = CW'(col_ff);

   always_comb begin
      result.out_byte      = item.eoi ? 8'h00 : item.data;
      result.action        = action;
      result.error_code    = err;
      result.line_number   = (line_ext > LINE_OUT_MAX) ? LINE_OUT_MAX[qefs_pkg::LINE_OUT_BITS-1:0]
                                                       : line_ext[qefs_pkg::LINE_OUT_BITS-1:0];
      result.column_number = (col_ext > COL_OUT_MAX) ? COL_OUT_MAX[qefs_pkg::COL_OUT_BITS-1:0]
                                                     : col_ext[qefs_pkg::COL_OUT_BITS-1:0];
   end

endmodule

[rtl/quoted_escaped_field_scanner.sv]
// Quoted/escaped field scanner, top level. A transaction accepted by push is
// classified into the item queue, then scanned by the back end and written into
// the result queue once that queue has room; results are read from that queue.
// Throughput: one byte per cycle while the result queue has room.
// Reset (synchronous, active high) empties both queues, restores the delimiter
// set to comma and the escape byte to backslash, and sets line 1, column 0.
module quoted_escaped_field_scanner #(
   parameter int LINE_BITS   = qefs_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = qefs_pkg::COLUMN_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = qefs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qefs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [qefs_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_cmd,
   input  logic [7:0]                          req_in_byte,
   output logic                                empty,
   input  logic                                pop,
   output logic [7:0]                          rsp_out_byte,
   output logic [1:0]                          rsp_action,
   output logic [1:0]                          rsp_error_code,
   output logic [qefs_pkg::LINE_OUT_BITS-1:0]  rsp_line_number,
   output logic [qefs_pkg::COL_OUT_BITS-1:0]   rsp_column_number
);

   qefs_pkg::scan_item_type   front_item;
   qefs_pkg::scan_item_type   back_item;
   qefs_pkg::scan_result_type back_result;
   qefs_pkg::scan_result_type rsp_result;
   logic                      item_empty;
   logic                      item_take;
   logic                      rsp_full;
   logic                      rsp_push;

   qefs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (req_cmd),
      .in_byte   (req_in_byte),
      .item      (front_item)
   );

   qefs_fifo #(
      .WIDTH ($bits(qefs_pkg::scan_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (item_take),
      .pop_data  (back_item),
      .empty     (item_empty)
   );

   qefs_back #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!item_empty),
      .item      (back_item),
      .in_take   (item_take),
      .out_ready (!rsp_full),
      .out_push  (rsp_push),
      .result    (back_result)
   );

   qefs_fifo #(
      .WIDTH ($bits(qefs_pkg::scan_result_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_result),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_result),
      .empty     (empty)
   );

   assign rsp_out_byte      = rsp_result.out_byte;
   assign rsp_action        = rsp_result.action;
   assign rsp_error_code    = rsp_result.error_code;
   assign rsp_line_number   = rsp_result.line_number;
   assign rsp_column_number = rsp_result.column_number;

`ifndef SYNTHESIS
   // an error always closes the token
   a_err_ends_token: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error_code != qefs_pkg::ERR_NONE) |->
      (rsp_action == qefs_pkg::ACT_TERM || rsp_action == qefs_pkg::ACT_EOI))
      else $error("error reported on a transaction that does not end a token");

   a_eoi_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_action == qefs_pkg::ACT_EOI) |-> (rsp_out_byte == 8'h00))
      else $error("end of input result carries a non-zero byte");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_line_number != '0))
      else $error("line number zero on result");

   // back end only moves an item when the result queue has room
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (!rsp_full && !item_empty))
      else $error("back end pushed into a full result queue");
`endif

endmodule
